/* sv/gf2alu_pkg.sv */
// Shared opcodes, control bundle and step-count constants for the GF(2) polynomial ALU.
package gf2alu_pkg;

   localparam int OPCODE_W = 3;
   localparam int SHIFT_W = 6;
   localparam int OPERAND_W = 32;
   localparam int RESULT_W = 63;
   localparam int STEPS_PER_STAGE = 4;

   localparam logic [OPCODE_W-1:0] OP_AND = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_XOR = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_MUL = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_REM = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_SHL = 3'd4;
   localparam logic [OPCODE_W-1:0] OP_SHR = 3'd5;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [SHIFT_W-1:0]  shift_amount;
      logic                b_zero;
   } ctrl_type;

endpackage

/* sv/gf2_polynomial_alu.sv */
// Top level of the GF(2) polynomial ALU: input register, divisor normalize, step slices, output.
//
// Streaming unit for binary polynomials: AND, XOR, carry-less multiply, remainder, and
// left/right shift of operand_a. One item enters per cycle while the pipeline advances. The
// accepting edge loads the input register, then one stage left-justifies the divisor, one
// stage handles each four multiply/reduce bits, and the output register follows.
// The whole pipeline advances together whenever the output register is empty or being
// taken, so a stall on the result side holds every item in place. A remainder with a
// zero divisor returns operand_a and sets divide_by_zero. Only the low WIDTH bits of
// each operand are used.
module gf2_polynomial_alu #(
   parameter int WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // opcode[2:0], operand_a[34:3], operand_b[66:35], shift_amount[72:67], zero[79:73]
   input  logic [79:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // result_value[62:0], divide_by_zero[63]
   output logic [63:0] rsp_tdata
);
   import gf2alu_pkg::*;

   localparam int SW = (WIDTH > 2) ? $clog2(WIDTH) : 1;
   localparam int NCORE = (WIDTH + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
   localparam int PW = 2 * WIDTH - 1;

   logic advance;

   logic             in_valid_ff;
   ctrl_type         in_ctrl_ff;
   logic [WIDTH-1:0] in_a_ff;
   logic [WIDTH-1:0] in_b_ff;

   logic [WIDTH-1:0] norm_bn;
   logic [SW-1:0]    norm_s;

   logic             c_valid_ff [NCORE+1];
   ctrl_type         c_ctrl_ff  [NCORE+1];
   logic [WIDTH-1:0] c_a_ff     [NCORE+1];
   logic [WIDTH-1:0] c_b_ff     [NCORE+1];
   logic [WIDTH-1:0] c_bn_ff    [NCORE+1];
   logic [SW-1:0]    c_s_ff     [NCORE+1];
   logic [PW-1:0]    c_acc_ff   [NCORE+1];
   logic [WIDTH-1:0] c_rem_ff   [NCORE+1];

   logic [PW-1:0]    acc_in [NCORE];
   logic [WIDTH-1:0] rem_in [NCORE];

   logic                rsp_valid_ff;
   logic [RESULT_W-1:0] rsp_value_ff;
   logic                rsp_dz_ff;
   logic [RESULT_W-1:0] rsp_value_in;
   logic                rsp_dz_in;

   assign advance = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {rsp_dz_ff, rsp_value_ff};

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_tvalid;
      end
      if (advance) begin
         in_ctrl_ff.opcode       <= req_tdata[2:0];
         in_ctrl_ff.shift_amount <= req_tdata[72:67];
         in_ctrl_ff.b_zero       <= (req_tdata[35 +: WIDTH] == '0);
         in_a_ff                 <= req_tdata[3 +: WIDTH];
         in_b_ff                 <= req_tdata[35 +: WIDTH];
      end
   end

   // left-justify the divisor; norm_s counts the positions moved
   always_comb begin
      norm_bn = in_b_ff;
      norm_s = '0;
      for (int k = SW - 1; k >= 0; k--) begin
         if ((norm_bn >> (WIDTH - (1 << k))) == '0) begin
            norm_bn = norm_bn << (1 << k);
            norm_s = norm_s | SW'(1 << k);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff[0] <= 1'b0;
      end else if (advance) begin
         c_valid_ff[0] <= in_valid_ff;
      end
      if (advance) begin
         c_ctrl_ff[0] <= in_ctrl_ff;
         c_a_ff[0]    <= in_a_ff;
         c_b_ff[0]    <= in_b_ff;
         c_bn_ff[0]   <= norm_bn;
         c_s_ff[0]    <= norm_s;
         c_acc_ff[0]  <= '0;
         c_rem_ff[0]  <= in_a_ff;
      end
   end

   for (genvar g = 0; g < NCORE; g++) begin : g_core
      gf2alu_steps #(
         .WIDTH(WIDTH),
         .BASE (g * STEPS_PER_STAGE),
         .SW   (SW)
      ) u_steps (
         .a       (c_a_ff[g]),
         .b       (c_b_ff[g]),
         .bn      (c_bn_ff[g]),
         .s       (c_s_ff[g]),
         .acc_cur (c_acc_ff[g]),
         .rem_cur (c_rem_ff[g]),
         .acc_next(acc_in[g]),
         .rem_next(rem_in[g])
      );

      always_ff @(posedge clock) begin
         if (reset) begin
            c_valid_ff[g+1] <= 1'b0;
         end else if (advance) begin
            c_valid_ff[g+1] <= c_valid_ff[g];
         end
         if (advance) begin
            c_ctrl_ff[g+1] <= c_ctrl_ff[g];
            c_a_ff[g+1]    <= c_a_ff[g];
            c_b_ff[g+1]    <= c_b_ff[g];
            c_bn_ff[g+1]   <= c_bn_ff[g];
            c_s_ff[g+1]    <= c_s_ff[g];
            c_acc_ff[g+1]  <= acc_in[g];
            c_rem_ff[g+1]  <= rem_in[g];
         end
      end
   end

   // result select from the last slice
   always_comb begin
      logic [WIDTH-1:0] a;
      logic [WIDTH-1:0] b;
      logic [WIDTH-1:0] shl;
      logic [WIDTH-1:0] shr;
      logic             wide_shift;
      a = c_a_ff[NCORE];
      b = c_b_ff[NCORE];
      wide_shift = (c_ctrl_ff[NCORE].shift_amount >= SHIFT_W'(WIDTH));
      shl = wide_shift ? '0 : (a << c_ctrl_ff[NCORE].shift_amount);
      shr = wide_shift ? '0 : (a >> c_ctrl_ff[NCORE].shift_amount);
      rsp_dz_in = 1'b0;
      unique case (c_ctrl_ff[NCORE].opcode)
         OP_AND: rsp_value_in = RESULT_W'(a & b);
         OP_XOR: rsp_value_in = RESULT_W'(a ^ b);
         OP_MUL: rsp_value_in = RESULT_W'(c_acc_ff[NCORE]);
         OP_REM: begin
            rsp_dz_in = c_ctrl_ff[NCORE].b_zero;
            rsp_value_in = c_ctrl_ff[NCORE].b_zero ? RESULT_W'(a)
                                                   : RESULT_W'(c_rem_ff[NCORE]);
         end
         OP_SHL: rsp_value_in = RESULT_W'(shl);
         OP_SHR: rsp_value_in = RESULT_W'(shr);
         default: rsp_value_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= c_valid_ff[NCORE];
      end
      if (advance) begin
         rsp_value_ff <= rsp_value_in;
         rsp_dz_ff    <= rsp_dz_in;
      end
   end

endmodule

/* sv/gf2alu_steps.sv */
// One pipeline slice: a few carry-less multiply bits and a few remainder reduction bits.
module gf2alu_steps #(
   parameter int WIDTH = 32,
   parameter int BASE = 0,
   parameter int SW = 5
) (
   input  logic [WIDTH-1:0]   a,
   input  logic [WIDTH-1:0]   b,
   input  logic [WIDTH-1:0]   bn,
   input  logic [SW-1:0]      s,
   input  logic [2*WIDTH-2:0] acc_cur,
   input  logic [WIDTH-1:0]   rem_cur,
   output logic [2*WIDTH-2:0] acc_next,
   output logic [WIDTH-1:0]   rem_next
);
   import gf2alu_pkg::*;

   always_comb begin
      int i;
      int ri;
      acc_next = acc_cur;
      rem_next = rem_cur;
      for (int t = 0; t < STEPS_PER_STAGE; t++) begin
         i = BASE + t;
         if (i < WIDTH) begin
            if (b[i]) begin
               acc_next = acc_next ^ ((2*WIDTH-1)'(a) << i);
            end
            // reduction of bit WIDTH-1-i, live only down to the divisor's degree
            ri = WIDTH - 1 - i;
            if (rem_next[ri] && (i <= int'(s))) begin
               rem_next = rem_next ^ (bn >> i);
            end
         end
      end
   end

endmodule

/* tb/sv/gf2_alu_checker.sv */
// Checker for the GF(2) polynomial ALU: predicts each request item and compares responses.
`timescale 1ns / 100ps

module gf2_alu_checker #(
   parameter int WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   // opcode[2:0], operand_a[34:3], operand_b[66:35], shift_amount[72:67], zero[79:73]
   input  logic [79:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   // result_value[62:0], divide_by_zero[63]
   input  logic [63:0] rsp_tdata,
   output int          error_count,
   output int          pending_count
);
   import gf2alu_pkg::*;

   localparam logic [63:0] VEC_MASK = (64'd1 << WIDTH) - 64'd1;

   typedef struct packed {
      logic [RESULT_W-1:0] value;
      logic                div_zero;
   } alu_result_type;

   alu_result_type pending_results[$];
   int             errors = 0;

   initial begin
      error_count = 0;
      pending_count = 0;
   end

   function automatic alu_result_type gf2_alu_predict(input logic [OPCODE_W-1:0] op,
                                                      input logic [OPERAND_W-1:0] a_in,
                                                      input logic [OPERAND_W-1:0] b_in,
                                                      input logic [SHIFT_W-1:0] sh);
      alu_result_type r;
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] acc;
      int          lead;
      a = 64'(a_in) & VEC_MASK;
      b = 64'(b_in) & VEC_MASK;
      acc = '0;
      lead = -1;
      r.div_zero = 1'b0;
      case (op)
         OP_AND: acc = a & b;
         OP_XOR: acc = a ^ b;
         OP_MUL: begin
            for (int i = 0; i < WIDTH; i++)
               if (b[i]) acc ^= a << i;
         end
         OP_REM: begin
            if (b == '0) begin
               r.div_zero = 1'b1;
               acc = a;
            end else begin
               for (int i = WIDTH - 1; i >= 0; i--)
                  if (b[i] && lead < 0) lead = i;
               acc = a;
               // long division: cancel every set bit at or above the divisor degree
               for (int i = WIDTH - 1; i >= lead; i--)
                  if (acc[i]) acc ^= b << (i - lead);
               acc &= VEC_MASK;
            end
         end
         OP_SHL: acc = (sh >= WIDTH) ? '0 : ((a << sh) & VEC_MASK);
         OP_SHR: acc = (sh >= WIDTH) ? '0 : (a >> sh);
         default: acc = '0;
      endcase
      r.value = acc[RESULT_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      alu_result_type want;
      alu_result_type got;
      if (!reset) begin
         if (req_tvalid && req_tready)
            pending_results.push_back(gf2_alu_predict(req_tdata[2:0], req_tdata[34:3],
                                                      req_tdata[66:35], req_tdata[72:67]));
         if (rsp_tvalid && rsp_tready) begin
            got.value = rsp_tdata[62:0];
            got.div_zero = rsp_tdata[63];
            if (pending_results.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: unexpected response value=%h dz=%b", $realtime,
                           got.value, got.div_zero);
            end else begin
               want = pending_results.pop_front();
               if (got.value !== want.value || got.div_zero !== want.div_zero) begin
                  errors++;
                  if (errors <= 10)
                     $display("%0t: mismatch exp value=%h dz=%b got value=%h dz=%b",
                              $realtime, want.value, want.div_zero, got.value,
                              got.div_zero);
               end
            end
         end
      end
      error_count <= errors;
      pending_count <= pending_results.size();
   end

endmodule

/* tb/sv/tb_gf2_polynomial_alu.sv */
// Top of the GF(2) polynomial ALU testbench: clock, reset, stimulus, back-pressure, verdict.
`timescale 1ns / 100ps

module tb_gf2_polynomial_alu;
   import gf2alu_pkg::*;

   localparam int RANDOM_ITEMS = 1950;
   localparam int HOLD_AT_ITEM = 600;
   localparam int HOLD_CYCLES = 400;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;

   int          error_count;
   int          pending_count;
   int          items_sent = 0;
   logic        req_no_idle = 1'b0;

   // response side pacing
   logic        rsp_hold = 1'b0;
   logic        rsp_no_idle = 1'b0;
   int          rsp_gap = 0;
   int          rsp_taken = 0;

   always #4 clock = ~clock;

   gf2_polynomial_alu #(.WIDTH(32)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   gf2_alu_checker #(.WIDTH(32)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   always @(posedge clock) begin
      int gap;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_gap <= 0;
      end else if (rsp_hold) begin
         rsp_tready <= 1'b0;
      end else if (rsp_tready && rsp_tvalid) begin
         rsp_taken <= rsp_taken + 1;
         if (rsp_taken % 256 == 255) rsp_no_idle <= ($urandom_range(0, 3) == 0);
         gap = rsp_no_idle ? 0 : $urandom_range(0, 9);
         rsp_gap <= gap;
         rsp_tready <= (gap == 0);
      end else if (!rsp_tready) begin
         if (rsp_gap <= 1) begin
            rsp_tready <= 1'b1;
            rsp_gap <= 0;
         end else begin
            rsp_gap <= rsp_gap - 1;
         end
      end
   end

   // long response stall while the sender keeps offering items
   initial begin
      wait (items_sent == HOLD_AT_ITEM);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   task automatic send_op(input logic [OPCODE_W-1:0] op, input logic [OPERAND_W-1:0] a,
                          input logic [OPERAND_W-1:0] b, input logic [SHIFT_W-1:0] sh);
      int gap;
      gap = req_no_idle ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'd0, sh, b, a, op};
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      items_sent++;
   endtask

   function automatic logic [OPERAND_W-1:0] rand_poly();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return 32'd1 << $urandom_range(0, 31);
         3: return $urandom & ((32'd1 << $urandom_range(1, 31)) - 32'd1);
         default: return $urandom;
      endcase
   endfunction

   initial begin
      logic [OPCODE_W-1:0] op;
      logic [SHIFT_W-1:0]  sh;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_op(OP_AND, '1, '1, 6'd0);
      send_op(OP_AND, 32'hA5A5_5A5A, 32'h0FF0_F00F, 6'd63);
      send_op(OP_XOR, '1, '0, 6'd0);
      send_op(OP_XOR, 32'h1234_5678, 32'h1234_5678, 6'd32);
      send_op(OP_MUL, '1, '1, 6'd0);
      send_op(OP_MUL, 32'h8000_0000, 32'h8000_0000, 6'd0);
      send_op(OP_MUL, 32'hDEAD_BEEF, '0, 6'd0);
      send_op(OP_MUL, 32'd1, 32'hCAFE_F00D, 6'd0);
      send_op(OP_REM, 32'hFFFF_0000, '0, 6'd0);      // zero divisor
      send_op(OP_REM, '1, 32'd1, 6'd0);
      send_op(OP_REM, 32'h0000_00FF, 32'h0001_0000, 6'd0); // divisor degree above dividend
      send_op(OP_REM, 32'h8765_4321, 32'h8765_4321, 6'd0);
      send_op(OP_REM, '1, 32'h8000_0000, 6'd0);
      send_op(OP_REM, 32'hFFFF_FFFF, 32'h0000_011B, 6'd0);
      send_op(OP_SHL, '1, '0, 6'd0);
      send_op(OP_SHL, '1, '0, 6'd31);
      send_op(OP_SHL, '1, '0, 6'd32);
      send_op(OP_SHL, '1, '1, 6'd63);
      send_op(OP_SHR, '1, '0, 6'd0);
      send_op(OP_SHR, '1, '0, 6'd31);
      send_op(OP_SHR, '1, '0, 6'd32);
      send_op(OP_SHR, '1, '1, 6'd40);
      send_op(3'd6, '1, '1, 6'd5);
      send_op(3'd7, '1, '1, 6'd63);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 150 == 0) req_no_idle = ($urandom_range(0, 3) == 0);
         op = ($urandom_range(0, 99) < 97) ? OPCODE_W'($urandom_range(0, 5))
                                           : OPCODE_W'($urandom_range(6, 7));
         sh = ($urandom_range(0, 9) < 9) ? SHIFT_W'($urandom_range(0, 32))
                                         : SHIFT_W'($urandom_range(33, 63));
         send_op(op, rand_poly(), rand_poly(), sh);
      end
      req_tvalid <= 1'b0;

      wait (pending_count == 0);
      repeat (30) @(posedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
